// ----- rtl/core/cau_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, operation codes and stage records for the complex ALU.
// ----------------------------------------------------------------------------
package cau_pkg;
    localparam int DW = 16;
    localparam int FB = 8;
    localparam int PW = 2 * DW;          // product width
    localparam int SW = PW + 1;          // sum of two products
    localparam int MW = SW - 1;          // magnitude of that sum
    localparam int NW = MW + FB;         // widened numerator
    localparam int QW = DW + 1;          // quotient bits kept (enough to detect saturation)
    localparam int QIW = $clog2(QW);     // quotient bit index
    localparam int DENW = PW;            // |b|^2 width (unsigned, fits 2*DW bits)

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]          func;
        logic                dz;
        logic                re_neg;
        logic                im_neg;
        logic [NW-1:0]       re_rem;
        logic [NW-1:0]       im_rem;
        logic [QW-1:0]       re_q;
        logic [QW-1:0]       im_q;
        logic                re_big;
        logic                im_big;
        logic [DENW-1:0]     den;
    } div_ctx_t;
endpackage
`default_nettype wire

// ----- rtl/core/cau_div_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_div_stage
// One registered restoring-division stage working both result parts.
// ----------------------------------------------------------------------------
module cau_div_stage
    import cau_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic [QIW-1:0] bit_idx,
    input  wire logic           vin,
    input  wire div_ctx_t       din,
    output logic                vout,
    output div_ctx_t            dout
);
    div_ctx_t next_c;
    logic [NW+DENW:0] dsh;
    logic [NW+DENW:0] rr;
    logic [NW+DENW:0] ri;

    always_comb
    begin
        next_c = din;
        dsh = {{(NW+1){1'b0}}, din.den} << bit_idx;
        rr = {{(DENW+1){1'b0}}, din.re_rem};
        ri = {{(DENW+1){1'b0}}, din.im_rem};
        if (rr >= dsh)
        begin
            next_c.re_rem = NW'(rr - dsh);
            next_c.re_q[bit_idx] = 1'b1;
        end
        if (ri >= dsh)
        begin
            next_c.im_rem = NW'(ri - dsh);
            next_c.im_q[bit_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout <= 1'b0;
        else if (en)
            vout <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout <= next_c;
    end
endmodule
`default_nettype wire

// ----- rtl/core/complex_arithmetic_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU: add, subtract, multiply, divide on Q7.8 operands.
// ----------------------------------------------------------------------------
// channel   dir  tdata (low bit up)                       tuser
// s_axis    in   a_re, a_im, b_re, b_im (64 bits)         func (2 bits)
// m_axis    out  res_re, res_im, overflow, div_by_zero    -
//
// One request enters per cycle while m_axis does not stall; stages: operands,
// products, sums, one stage per quotient bit of the restoring divider, then saturation.
// The divider shares the pipe with every op, so all ops take the same path.
// rst_n clears all valid bits; payload registers are not reset.
// A stall on m_axis freezes the whole pipe (global enable); s_axis_tready
// stays high while the output register is empty or being drained.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // a_re, a_im, b_re, b_im
    input  wire logic [1:0]  s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // res_re, res_im, overflow, div_by_zero, 6 zero
);
    localparam int NS = QW;

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: register operands
    logic s1_v_reg;
    logic [1:0] s1_func_reg;
    logic signed [DW-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= s_axis_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_func_reg <= s_axis_tuser;
            ar_reg <= s_axis_tdata[15:0];
            ai_reg <= s_axis_tdata[31:16];
            br_reg <= s_axis_tdata[47:32];
            bi_reg <= s_axis_tdata[63:48];
        end
    end

    // Stage 2: six products (four cross terms, two squares for |b|^2) plus add/sub
    logic s2_v_reg;
    logic [1:0] s2_func_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, b2r_reg, b2i_reg;
    logic signed [DW:0] as_re_reg, as_im_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= s1_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_func_reg <= s1_func_reg;
            p_rr_reg <= ar_reg * br_reg;
            p_ii_reg <= ai_reg * bi_reg;
            p_ri_reg <= ar_reg * bi_reg;
            p_ir_reg <= ai_reg * br_reg;
            b2r_reg <= br_reg * br_reg;
            b2i_reg <= bi_reg * bi_reg;
            if (s1_func_reg == FUNC_SUB)
            begin
                as_re_reg <= (DW+1)'(ar_reg) - (DW+1)'(br_reg);
                as_im_reg <= (DW+1)'(ai_reg) - (DW+1)'(bi_reg);
            end
            else
            begin
                as_re_reg <= (DW+1)'(ar_reg) + (DW+1)'(br_reg);
                as_im_reg <= (DW+1)'(ai_reg) + (DW+1)'(bi_reg);
            end
        end
    end

    // Stage 3: sums of products, sign/magnitude, divisor
    logic signed [SW-1:0] sr, si;
    logic [SW-1:0] mr, mi;
    logic [DENW:0] den_w;
    div_ctx_t c0;
    logic s3_v_reg;
    div_ctx_t s3_reg;
    logic signed [DW:0] s3_asre_reg, s3_asim_reg;
    always_comb
    begin
        if (s2_func_reg == FUNC_MUL)
        begin
            sr = SW'(p_rr_reg) - SW'(p_ii_reg);
            si = SW'(p_ri_reg) + SW'(p_ir_reg);
        end
        else
        begin
            sr = SW'(p_rr_reg) + SW'(p_ii_reg);
            si = SW'(p_ir_reg) - SW'(p_ri_reg);
        end
        mr = sr[SW-1] ? SW'(-sr) : SW'(sr);
        mi = si[SW-1] ? SW'(-si) : SW'(si);
        den_w = (DENW+1)'(b2r_reg) + (DENW+1)'(b2i_reg);
        c0 = '0;
        c0.func = s2_func_reg;
        c0.re_neg = sr[SW-1];
        c0.im_neg = si[SW-1];
        c0.den = DENW'(den_w);
        c0.dz = (den_w == '0);
        if (s2_func_reg == FUNC_MUL)
        begin
            c0.re_big = (mr[MW-1:FB] > MW'(2**(DW-1)));
            c0.im_big = (mi[MW-1:FB] > MW'(2**(DW-1)));
            c0.re_q = QW'(mr[MW-1:FB]);
            c0.im_q = QW'(mi[MW-1:FB]);
        end
        else
        begin
            c0.re_rem = {mr[MW-1:0], {FB{1'b0}}};
            c0.im_rem = {mi[MW-1:0], {FB{1'b0}}};
            // quotient needs more than QW bits when numerator / 2^QW >= den
            c0.re_big = (DENW'(mr[MW-1:QW-FB]) >= c0.den) && !c0.dz;
            c0.im_big = (DENW'(mi[MW-1:QW-FB]) >= c0.den) && !c0.dz;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (en)
            s3_v_reg <= s2_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= c0;
            s3_asre_reg <= as_re_reg;
            s3_asim_reg <= as_im_reg;
        end
    end

    // Divider: one stage per quotient bit, MSB first
    logic [NS:0] dv;
    div_ctx_t dc [NS+1];
    logic signed [DW:0] asre_d [NS+1];
    logic signed [DW:0] asim_d [NS+1];
    assign dv[0] = s3_v_reg;
    assign dc[0] = s3_reg;
    assign asre_d[0] = s3_asre_reg;
    assign asim_d[0] = s3_asim_reg;
    for (genvar g = 0; g < NS; g++)
    begin : g_div
        div_ctx_t din_c;
        always_comb
        begin
            din_c = dc[g];
            if (dc[g].func != FUNC_DIV || dc[g].dz)
                din_c.den = '1;
        end
        div_ctx_t dout_c;
        cau_div_stage u_stage
        (
            .clk(clk), .rst_n(rst_n), .en(en), .bit_idx(QIW'(NS-1-g)),
            .vin(dv[g]), .din(din_c), .vout(dv[g+1]), .dout(dout_c)
        );
        always_comb
        begin
            dc[g+1] = dout_c;
            if (dout_c.func != FUNC_DIV)
            begin
                dc[g+1].re_q = dout_c.re_q;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                asre_d[g+1] <= asre_d[g];
                asim_d[g+1] <= asim_d[g];
            end
        end
    end

    // Final stage: saturate and pack
    div_ctx_t f;
    logic signed [DW-1:0] ore, oim;
    logic ov;
    logic [QW:0] lim_p, lim_n;
    always_comb
    begin
        f = dc[NS];
        ov = 1'b0;
        ore = '0;
        oim = '0;
        lim_p = (QW+1)'(2**(DW-1) - 1);
        lim_n = (QW+1)'(2**(DW-1));
        case (f.func)
            FUNC_ADD, FUNC_SUB:
            begin
                if (asre_d[NS] > (DW+1)'(2**(DW-1)-1))
                begin
                    ore = '1;
                    ore[DW-1] = 1'b0;
                    ov = 1'b1;
                end
                else if (asre_d[NS] < -(DW+1)'(2**(DW-1)))
                begin
                    ore = '0;
                    ore[DW-1] = 1'b1;
                    ov = 1'b1;
                end
                else
                    ore = DW'(asre_d[NS]);
                if (asim_d[NS] > (DW+1)'(2**(DW-1)-1))
                begin
                    oim = '1;
                    oim[DW-1] = 1'b0;
                    ov = 1'b1;
                end
                else if (asim_d[NS] < -(DW+1)'(2**(DW-1)))
                begin
                    oim = '0;
                    oim[DW-1] = 1'b1;
                    ov = 1'b1;
                end
                else
                    oim = DW'(asim_d[NS]);
            end
            default:
            begin
                if (!(f.func == FUNC_DIV && f.dz))
                begin
                    if (!f.re_neg && (f.re_big || {1'b0, f.re_q} > lim_p))
                    begin
                        ore = '1;
                        ore[DW-1] = 1'b0;
                        ov = 1'b1;
                    end
                    else if (f.re_neg && (f.re_big || {1'b0, f.re_q} > lim_n))
                    begin
                        ore = '0;
                        ore[DW-1] = 1'b1;
                        ov = 1'b1;
                    end
                    else
                        ore = f.re_neg ? DW'(-f.re_q) : DW'(f.re_q);
                    if (!f.im_neg && (f.im_big || {1'b0, f.im_q} > lim_p))
                    begin
                        oim = '1;
                        oim[DW-1] = 1'b0;
                        ov = 1'b1;
                    end
                    else if (f.im_neg && (f.im_big || {1'b0, f.im_q} > lim_n))
                    begin
                        oim = '0;
                        oim[DW-1] = 1'b1;
                        ov = 1'b1;
                    end
                    else
                        oim = f.im_neg ? DW'(-f.im_q) : DW'(f.im_q);
                end
            end
        endcase
    end

    logic out_v_reg;
    logic [39:0] out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= dv[NS];
    end
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= {6'b0, (f.func == FUNC_DIV) && f.dz, ov, oim, ore};
    end
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = out_reg;
endmodule
`default_nettype wire

// ----- rtl/core/cau_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks for the complex ALU.
// ----------------------------------------------------------------------------
module cau_checker
    import cau_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[31:0] == 32'd0 && !m_axis_tdata[32])
        else $error("divide by zero result not clean");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("stalled with empty output");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0)
        else $error("pad bits set");
endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker
(
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
